@@ hw/rtl/cpd_pkg.sv @@
package cpd_pkg;

   // payload of one input transfer
   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } req_payload_type;

   // payload of one result transfer
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  element_index;
      logic [6:0]  char_out;
      logic [31:0] parsed_id;
      logic [3:0]  error_code;
      logic        message_done;
   } rsp_payload_type;

   // result kinds
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_CHAR = 2'd1;
   localparam logic [1:0] KIND_ID   = 2'd2;
   localparam logic [1:0] KIND_SEP  = 2'd3;

   // error codes
   localparam logic [3:0] ERR_NONE         = 4'd0;
   localparam logic [3:0] ERR_ID_REPEAT    = 4'd1;
   localparam logic [3:0] ERR_OPEN_AT_END  = 4'd2;
   localparam logic [3:0] ERR_UNTERMINATED = 4'd3;
   localparam logic [3:0] ERR_ID_EMPTY     = 4'd4;
   localparam logic [3:0] ERR_ID_LONG      = 4'd5;
   localparam logic [3:0] ERR_ID_ZERO      = 4'd6;
   localparam logic [3:0] ERR_END_AFTER_ID = 4'd7;
   localparam logic [3:0] ERR_MANY_ELEM    = 4'd8;
   localparam logic [3:0] ERR_ELEM_LONG    = 4'd9;

   // character constants
   localparam logic [7:0] CHAR_OPEN     = 8'h28;
   localparam logic [7:0] CHAR_CLOSE    = 8'h29;
   localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
   localparam logic [7:0] CHAR_PRINT_HI = 8'h7E;
   localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;
   localparam logic [7:0] SEP_RESET     = 8'h21;

   localparam logic [5:0]  ID_MAX_CHARS = 6'd32;
   localparam logic [31:0] ID_SAT       = 32'hFFFF_FFFF;

   typedef enum logic {
      MODE_DATA,
      MODE_ID
   } mode_type;

   // byte classification produced by the front end
   typedef struct packed {
      logic is_open;
      logic is_close;
      logic is_sep;
      logic is_print;
      logic is_digit;
   } byte_class_type;

   // one entry of the front-to-back queue
   typedef struct packed {
      logic [7:0]     byte_val;
      logic           last_byte;
      byte_class_type cls;
   } entry_type;

endpackage

@@ hw/rtl/cpd_fifo.sv @@
module cpd_fifo #(
   parameter type entry_type = logic,
   parameter int  DEPTH      = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              push_ok, pop_ok;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/cpd_front.sv @@
module cpd_front (
   input  cpd_pkg::req_payload_type req_item,
   input  logic [7:0]               separator,
   output cpd_pkg::entry_type       entry
);

   logic [7:0] b;

   assign b = req_item.byte_in;

   always_comb begin
      entry.byte_val     = b;
      entry.last_byte    = req_item.last_byte;
      entry.cls.is_open  = (b == cpd_pkg::CHAR_OPEN);
      entry.cls.is_close = (b == cpd_pkg::CHAR_CLOSE);
      entry.cls.is_sep   = (b == separator);
      entry.cls.is_print = (b >= cpd_pkg::CHAR_PRINT_LO) && (b <= cpd_pkg::CHAR_PRINT_HI);
      entry.cls.is_digit = (b >= cpd_pkg::CHAR_DIGIT_LO) && (b <= cpd_pkg::CHAR_DIGIT_HI);
   end

endmodule

@@ hw/rtl/cpd_back.sv @@
module cpd_back #(
   parameter int MAX_ELEMENTS    = 8,
   parameter int ELEMENT_MAX_LEN = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cpd_pkg::entry_type       q_entry,
   input  logic                     q_empty,
   output logic                     q_pop,
   input  logic                     rsp_full,
   output logic                     rsp_push,
   output cpd_pkg::rsp_payload_type rsp_item
);

   localparam int CNT_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int LEN_W = $clog2(ELEMENT_MAX_LEN + 1);

   cpd_pkg::mode_type mode_ff, mode_in;
   logic              id_seen_ff, id_seen_in;
   logic [31:0]       acc_ff, acc_in;
   logic [5:0]        char_cnt_ff, char_cnt_in;
   logic              stopped_ff, stopped_in;
   logic [CNT_W-1:0]  elem_cnt_ff, elem_cnt_in;
   logic [LEN_W-1:0]  elem_len_ff, elem_len_in;
   logic [3:0]        err_ff, err_in;

   logic              step;
   logic              last;
   logic [3:0]        digit;
   logic [35:0]       acc_sum;
   logic [31:0]       acc_digit;
   logic [CNT_W:0]    elem_cnt_inc;
   logic [LEN_W:0]    elem_len_inc;
   logic [CNT_W+2:0]  idx_wide;

   // step decisions
   logic [3:0]        err_det;
   logic              close_ok, open_ok, sep_ok, print_ok, id_char;

   // post-step values, before the end-of-message clear
   logic              id_seen_st;
   logic [CNT_W-1:0]  elem_cnt_st;
   logic [3:0]        err_st;

   assign q_pop    = !q_empty && !rsp_full;
   assign rsp_push = q_pop;
   assign step     = q_pop;
   assign last     = q_entry.last_byte;

   // acc * 10 + digit, saturating at 32 bits
   assign digit     = q_entry.byte_val[3:0];
   assign acc_sum   = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + 36'(digit);
   assign acc_digit = (|acc_sum[35:32]) ? cpd_pkg::ID_SAT : acc_sum[31:0];

   assign elem_cnt_inc = {1'b0, elem_cnt_ff} + 1'b1;
   assign elem_len_inc = {1'b0, elem_len_ff} + 1'b1;

   always_comb begin
      err_det  = cpd_pkg::ERR_NONE;
      close_ok = 1'b0;
      open_ok  = 1'b0;
      sep_ok   = 1'b0;
      print_ok = 1'b0;
      id_char  = 1'b0;
      if (err_ff == cpd_pkg::ERR_NONE) begin
         if (mode_ff == cpd_pkg::MODE_ID) begin
            if (q_entry.cls.is_close) begin
               if (char_cnt_ff == '0) begin
                  err_det = cpd_pkg::ERR_ID_EMPTY;
               end else if (char_cnt_ff > cpd_pkg::ID_MAX_CHARS) begin
                  err_det = cpd_pkg::ERR_ID_LONG;
               end else if (acc_ff == '0) begin
                  err_det = cpd_pkg::ERR_ID_ZERO;
               end else if (last) begin
                  err_det = cpd_pkg::ERR_END_AFTER_ID;
               end else begin
                  close_ok = 1'b1;
               end
            end else if (last) begin
               err_det = cpd_pkg::ERR_UNTERMINATED;
            end else begin
               id_char = 1'b1;
            end
         end else if (q_entry.cls.is_open) begin
            if (id_seen_ff) begin
               err_det = cpd_pkg::ERR_ID_REPEAT;
            end else if (last) begin
               err_det = cpd_pkg::ERR_OPEN_AT_END;
            end else begin
               open_ok = 1'b1;
            end
         end else if (q_entry.cls.is_sep) begin
            if (elem_cnt_inc >= (CNT_W + 1)'(MAX_ELEMENTS)) begin
               err_det = cpd_pkg::ERR_MANY_ELEM;
            end else begin
               sep_ok = 1'b1;
            end
         end else if (q_entry.cls.is_print) begin
            if (elem_len_inc >= (LEN_W + 1)'(ELEMENT_MAX_LEN)) begin
               err_det = cpd_pkg::ERR_ELEM_LONG;
            end else begin
               print_ok = 1'b1;
            end
         end
      end
   end

   // next parse mode
   always_comb begin
      mode_in = mode_ff;
      if (step) begin
         if (last || close_ok) begin
            mode_in = cpd_pkg::MODE_DATA;
         end else if (open_ok) begin
            mode_in = cpd_pkg::MODE_ID;
         end
      end
   end

   // datapath and result
   always_comb begin
      id_seen_st  = id_seen_ff || close_ok;
      elem_cnt_st = sep_ok ? elem_cnt_inc[CNT_W-1:0] : elem_cnt_ff;
      err_st      = (err_det != cpd_pkg::ERR_NONE) ? err_det : err_ff;

      id_seen_in  = id_seen_ff;
      acc_in      = acc_ff;
      char_cnt_in = char_cnt_ff;
      stopped_in  = stopped_ff;
      elem_cnt_in = elem_cnt_ff;
      elem_len_in = elem_len_ff;
      err_in      = err_ff;

      if (step) begin
         id_seen_in  = id_seen_st;
         elem_cnt_in = elem_cnt_st;
         err_in      = err_st;
         if (open_ok) begin
            acc_in      = '0;
            char_cnt_in = '0;
            stopped_in  = 1'b0;
         end
         if (id_char) begin
            if (char_cnt_ff <= cpd_pkg::ID_MAX_CHARS) begin
               char_cnt_in = char_cnt_ff + 1'b1;
            end
            if (!stopped_ff && q_entry.cls.is_digit) begin
               acc_in = acc_digit;
            end else begin
               stopped_in = 1'b1;
            end
         end
         if (sep_ok) begin
            elem_len_in = '0;
         end
         if (print_ok) begin
            elem_len_in = elem_len_inc[LEN_W-1:0];
         end
         if (last) begin
            id_seen_in  = 1'b0;
            acc_in      = '0;
            char_cnt_in = '0;
            stopped_in  = 1'b0;
            elem_cnt_in = '0;
            elem_len_in = '0;
            err_in      = cpd_pkg::ERR_NONE;
         end
      end

      idx_wide = (CNT_W + 3)'(elem_cnt_st);

      rsp_item.kind          = cpd_pkg::KIND_NONE;
      rsp_item.element_index = idx_wide[2:0];
      rsp_item.char_out      = '0;
      rsp_item.parsed_id     = '0;
      rsp_item.error_code    = err_st;
      rsp_item.message_done  = last;
      if (close_ok) begin
         rsp_item.kind      = cpd_pkg::KIND_ID;
         rsp_item.parsed_id = acc_ff;
      end else if (sep_ok) begin
         rsp_item.kind = cpd_pkg::KIND_SEP;
      end else if (print_ok) begin
         rsp_item.kind     = cpd_pkg::KIND_CHAR;
         rsp_item.char_out = q_entry.byte_val[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= cpd_pkg::MODE_DATA;
         id_seen_ff  <= 1'b0;
         acc_ff      <= '0;
         char_cnt_ff <= '0;
         stopped_ff  <= 1'b0;
         elem_cnt_ff <= '0;
         elem_len_ff <= '0;
         err_ff      <= cpd_pkg::ERR_NONE;
      end else begin
         mode_ff     <= mode_in;
         id_seen_ff  <= id_seen_in;
         acc_ff      <= acc_in;
         char_cnt_ff <= char_cnt_in;
         stopped_ff  <= stopped_in;
         elem_cnt_ff <= elem_cnt_in;
         elem_len_ff <= elem_len_in;
         err_ff      <= err_in;
      end
   end

   // a result that reports an error carries no result kind
   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_push && (rsp_item.error_code != cpd_pkg::ERR_NONE)
      |-> rsp_item.kind == cpd_pkg::KIND_NONE)
      else $error("result kind set while an error is reported");

   // message end returns the parser to its idle state
   a_msg_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_push && rsp_item.message_done
      |=> (mode_ff == cpd_pkg::MODE_DATA) && (err_ff == cpd_pkg::ERR_NONE)
          && !id_seen_ff && (elem_cnt_ff == '0) && (elem_len_ff == '0))
      else $error("parser state not cleared after message end");

   // an id result implies the id is recorded for the rest of the message
   a_id_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_push && (rsp_item.kind == cpd_pkg::KIND_ID)
      |=> id_seen_ff && (mode_ff == cpd_pkg::MODE_DATA))
      else $error("completed id not recorded");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, elem_cnt_ff} < (CNT_W + 1)'(MAX_ELEMENTS))
      else $error("element counter out of range");

endmodule

@@ hw/rtl/chat_packet_deframer_unit.sv @@
// channel   ports                         transfer when
// req       req_push/req_full/req_data    req_push && !req_full
// rsp       rsp_pop/rsp_empty/rsp_data    rsp_pop && !rsp_empty
// csr       csr_psel/penable/pwrite/...   psel && penable && pwrite (pready tied high)
//
// One byte per cycle sustained while rsp is not stalled: the front classifies on the req
// transfer cycle, the classify queue registers the byte, the back pops it when rsp has room,
// and its result is registered in the result queue before it shows on rsp.
// rsp stalls back up through the result queue and the 2-entry classify queue.
// Synchronous reset: separator returns to '!', parser state clears, queues empty.
// No clearing pass; the block takes bytes the cycle after reset drops.
module chat_packet_deframer_unit #(
   parameter int MAX_ELEMENTS    = 8,
   parameter int ELEMENT_MAX_LEN = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   // byte input channel
   input  logic                     req_push,
   output logic                     req_full,
   input  cpd_pkg::req_payload_type req_data,
   // result channel
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output cpd_pkg::rsp_payload_type rsp_data,
   // register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   // register index = byte address / 4; only the separator exists
   localparam logic CSR_IDX_SEPARATOR = 1'b0;

   logic [7:0]               separator_ff, separator_in;
   logic                     csr_write;
   cpd_pkg::entry_type       front_entry;
   cpd_pkg::entry_type       q_entry;
   logic                     q_empty;
   logic                     q_pop;
   logic                     rsp_full;
   logic                     rsp_push;
   cpd_pkg::rsp_payload_type rsp_item;

   // ---- configuration ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      separator_in = separator_ff;
      if (csr_write && (csr_paddr[2] == CSR_IDX_SEPARATOR)) begin
         separator_in = csr_pwdata[7:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_SEPARATOR) begin
         csr_prdata = {24'd0, separator_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff <= cpd_pkg::SEP_RESET;
      end else begin
         separator_ff <= separator_in;
      end
   end

   // ---- front: classify each byte on its way in ----
   cpd_front u_front (
      .req_item  (req_data),
      .separator (separator_ff),
      .entry     (front_entry)
   );

   // short queue so the front keeps taking bytes while the back waits on rsp
   cpd_fifo #(
      .entry_type (cpd_pkg::entry_type),
      .DEPTH      (2)
   ) u_class_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_entry),
      .full      (req_full),
      .pop       (q_pop),
      .pop_data  (q_entry),
      .empty     (q_empty)
   );

   // ---- back: parse state machine, one byte per cycle while the result queue has room ----
   cpd_back #(
      .MAX_ELEMENTS    (MAX_ELEMENTS),
      .ELEMENT_MAX_LEN (ELEMENT_MAX_LEN)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_entry  (q_entry),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_full (rsp_full),
      .rsp_push (rsp_push),
      .rsp_item (rsp_item)
   );

   // result queue decouples the parser from the consumer's pop
   cpd_fifo #(
      .entry_type (cpd_pkg::rsp_payload_type),
      .DEPTH      (2)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_item),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule
